>>> hw/rtl/itda_pkg.sv
// ----------------------------------------------------------------------------
// itda_pkg
// Shared widths, character codes and sizes for the decimal ASCII converter.
// ----------------------------------------------------------------------------
package itda_pkg;

    // Input and output field widths
    localparam int KIND_W   = 1;
    localparam int VALUE_W  = 64;
    localparam int PAD_W    = 6;
    localparam int CHAR_W   = 8;

    // Largest pad length honored; longer requests saturate here
    localparam int MAX_PAD  = 32;

    // Decimal digits needed for a 64-bit magnitude, packed BCD width
    localparam int MAX_DIGITS = 20;
    localparam int BCD_W      = 4 * MAX_DIGITS;
    localparam int DIG_W      = $clog2(MAX_DIGITS + 1);
    localparam int BIT_CNT_W  = $clog2(VALUE_W);

    // Longest text: sign plus all digits, or the pad length
    localparam int MAX_LEN  = (MAX_PAD > MAX_DIGITS + 1) ? MAX_PAD : MAX_DIGITS + 1;
    localparam int LEN_W    = $clog2(MAX_LEN + 1);
    localparam int CALC_W   = ((LEN_W > PAD_W) ? LEN_W : PAD_W) + 1;

    // Character codes
    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'd45;

    // Signedness kinds
    localparam logic [KIND_W-1:0] KIND_UNSIGNED = 1'b0;
    localparam logic [KIND_W-1:0] KIND_SIGNED   = 1'b1;

endpackage

>>> hw/rtl/itda_if.sv
// ----------------------------------------------------------------------------
// itda_in_if / itda_out_if
// Valid/ready channels for the number beat and the character beat.
// ----------------------------------------------------------------------------
interface itda_in_if;
    import itda_pkg::*;

    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  kind;
    logic [VALUE_W-1:0] value;
    logic [PAD_W-1:0]   pad_length;

    modport source (output valid, kind, value, pad_length, input ready);
    modport sink   (input valid, kind, value, pad_length, output ready);
endinterface

interface itda_out_if;
    import itda_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] text_char;
    logic              last;

    modport source (output valid, text_char, last, input ready);
    modport sink   (input valid, text_char, last, output ready);
endinterface

>>> hw/rtl/itda_conv.sv
// ----------------------------------------------------------------------------
// itda_conv
// Bit-serial binary to BCD (shift and add-3), one magnitude bit per cycle,
// then a leading-zero strip one digit per cycle. Result is left aligned.
// ----------------------------------------------------------------------------
module itda_conv (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [itda_pkg::VALUE_W-1:0]  i_bin,
    output logic                          o_done,
    output logic [itda_pkg::BCD_W-1:0]    o_bcd,
    output logic [itda_pkg::DIG_W-1:0]    o_ndig
);
    import itda_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SHIFT,
        S_SCAN
    } t_state;

    t_state                 r_state;
    logic [VALUE_W-1:0]     r_bin;
    logic [BCD_W-1:0]       r_bcd;
    logic [BIT_CNT_W-1:0]   r_bitcnt;
    logic [DIG_W-1:0]       r_ndig;
    logic                   r_done;
    logic [BCD_W-1:0]       n_adj;

    // Add 3 to every digit of 5 or more before the shift
    always_comb begin
        for (int d = 0; d < MAX_DIGITS; d++) begin
            n_adj[4*d +: 4] = (r_bcd[4*d +: 4] >= 4'd5) ? r_bcd[4*d +: 4] + 4'd3
                                                        : r_bcd[4*d +: 4];
        end
    end

    // Sequencer and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_bin    <= i_bin;
                        r_bcd    <= '0;
                        r_bitcnt <= '0;
                        r_state  <= S_SHIFT;
                    end
                end
                S_SHIFT: begin
                    r_bcd    <= {n_adj[BCD_W-2:0], r_bin[VALUE_W-1]};
                    r_bin    <= {r_bin[VALUE_W-2:0], 1'b0};
                    r_bitcnt <= r_bitcnt + 1'b1;
                    if (r_bitcnt == BIT_CNT_W'(VALUE_W - 1)) begin
                        r_ndig  <= DIG_W'(MAX_DIGITS);
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    // strip one leading zero digit a cycle, keep at least one
                    if (r_bcd[BCD_W-1 -: 4] == 4'd0 && r_ndig > DIG_W'(1)) begin
                        r_bcd  <= {r_bcd[BCD_W-5:0], 4'd0};
                        r_ndig <= r_ndig - 1'b1;
                    end else begin
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_bcd  = r_bcd;
    assign o_ndig = r_ndig;

endmodule

>>> hw/rtl/int_to_decimal_ascii_unit.sv
// ----------------------------------------------------------------------------
// int_to_decimal_ascii_unit
// Converts a 64-bit number to zero-padded decimal ASCII, one character a beat.
// ----------------------------------------------------------------------------
// One number is in flight at a time. After a number beat is taken, the
// converter shifts the magnitude through the BCD adjust chain (one bit
// a cycle), then strips leading zero digits, then sends one character
// beat per cycle while the sink is ready: an optional '-', pad zeros,
// then the digits, with last on the final character. Without sink stalls
// the bit-serial BCD loop sets most of the time from one number beat to
// the next. The next number beat is taken once the final character sits
// in the output register.
module int_to_decimal_ascii_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    itda_in_if.sink    i_item,
    itda_out_if.source o_text
);
    import itda_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_SIGN,
        S_ZEROS,
        S_DIGITS
    } t_state;

    t_state              r_state;
    logic                r_neg;
    logic [LEN_W-1:0]    r_pad;
    logic [LEN_W-1:0]    r_zeros;
    logic [LEN_W-1:0]    r_remain;
    logic [BCD_W-1:0]    r_digits;
    logic                r_out_valid;
    logic [CHAR_W-1:0]   r_out_char;
    logic                r_out_last;

    logic                n_accept;
    logic                n_neg;
    logic [VALUE_W-1:0]  n_mag;
    logic [CALC_W-1:0]   n_pad_in;
    logic                conv_done;
    logic [BCD_W-1:0]    conv_bcd;
    logic [DIG_W-1:0]    conv_ndig;
    logic [CALC_W-1:0]   n_text_len;
    logic [CALC_W-1:0]   n_zeros;
    logic                n_load;
    logic                n_emit;

    // Input side: sign and magnitude, pad saturation
    assign n_accept = i_item.valid && i_item.ready;
    assign n_neg    = (i_item.kind == KIND_SIGNED) && i_item.value[VALUE_W-1];
    assign n_mag    = n_neg ? (~i_item.value + 1'b1) : i_item.value;
    assign n_pad_in = (CALC_W'(i_item.pad_length) > CALC_W'(MAX_PAD))
                    ? CALC_W'(MAX_PAD) : CALC_W'(i_item.pad_length);

    itda_conv u_conv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (n_accept),
        .i_bin   (n_mag),
        .o_done  (conv_done),
        .o_bcd   (conv_bcd),
        .o_ndig  (conv_ndig)
    );

    // Text length and pad zeros once the digit count is known
    assign n_text_len = CALC_W'(conv_ndig) + CALC_W'(r_neg);
    assign n_zeros    = (CALC_W'(r_pad) > n_text_len) ? CALC_W'(r_pad) - n_text_len
                                                       : '0;

    // Output register free for the next beat
    assign n_load = !r_out_valid || o_text.ready;

    // A character is loaded this cycle
    assign n_emit = n_load && ((r_state == S_SIGN) || (r_state == S_ZEROS)
                               || (r_state == S_DIGITS));

    // Control and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (n_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_text.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (n_accept) begin
                        r_neg   <= n_neg;
                        r_pad   <= LEN_W'(n_pad_in);
                        r_state <= S_CONV;
                    end
                end
                S_CONV: begin
                    if (conv_done) begin
                        r_digits <= conv_bcd;
                        r_zeros  <= LEN_W'(n_zeros);
                        r_remain <= LEN_W'(n_text_len + n_zeros);
                        if (r_neg) begin
                            r_state <= S_SIGN;
                        end else if (n_zeros != '0) begin
                            r_state <= S_ZEROS;
                        end else begin
                            r_state <= S_DIGITS;
                        end
                    end
                end
                S_SIGN: begin
                    if (n_load) begin
                        r_out_char  <= ASCII_MINUS;
                        r_out_last  <= (r_remain == LEN_W'(1));
                        r_remain    <= r_remain - 1'b1;
                        r_state     <= (r_zeros != '0) ? S_ZEROS : S_DIGITS;
                    end
                end
                S_ZEROS: begin
                    if (n_load) begin
                        r_out_char  <= ASCII_ZERO;
                        r_out_last  <= (r_remain == LEN_W'(1));
                        r_remain    <= r_remain - 1'b1;
                        r_zeros     <= r_zeros - 1'b1;
                        if (r_zeros == LEN_W'(1)) begin
                            r_state <= S_DIGITS;
                        end
                    end
                end
                S_DIGITS: begin
                    if (n_load) begin
                        r_out_char  <= ASCII_ZERO + CHAR_W'(r_digits[BCD_W-1 -: 4]);
                        r_out_last  <= (r_remain == LEN_W'(1));
                        r_remain    <= r_remain - 1'b1;
                        r_digits    <= {r_digits[BCD_W-5:0], 4'd0};
                        if (r_remain == LEN_W'(1)) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_item.ready     = (r_state == S_IDLE);
    assign o_text.valid     = r_out_valid;
    assign o_text.text_char = r_out_char;
    assign o_text.last      = r_out_last;

endmodule
